@@ rtl/bounded_id_set_assert.svh @@
// Assertion helpers for the modules of the identifier set.
`ifndef BOUNDED_ID_SET_ASSERT_SVH
`define BOUNDED_ID_SET_ASSERT_SVH

// Concurrent assertion on an explicit clock and reset.
`define BIS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define BIS_ASSERT(label, prop, msg) \
   `BIS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/bis_pkg.sv @@
package bis_pkg;

   localparam int ID_W    = 32;
   localparam int COUNT_W = 6;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_DEL   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [ID_W-1:0] RESERVED_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [ID_W-1:0] ident;
   } req_type;

   typedef struct packed {
      logic               success;
      logic               found;
      logic [COUNT_W-1:0] count;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

endpackage

@@ rtl/bounded_id_set.sv @@
// Set of up to CAPACITY distinct 32-bit identifiers with add, delete and
// membership query requests; every request returns one response with the
// status and the occupancy after the operation. The table sits in one
// synchronous RAM with a single read port, scanned one entry per cycle up to
// a match or the end, so at most the current count of entries is scanned; a
// successful delete then moves the last entry into the freed slot. A response
// held by rsp_stall stays in the output register while the next request is
// accepted and scanned. The reserved identifier, written through csr_we, is
// always rejected by add and delete and must only be changed while the block
// is idle.
module bounded_id_set #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bis_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bis_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);
   import bis_pkg::*;

   logic [ID_W-1:0] reserved_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            out_free;
   logic            res_done;
   rsp_type         res;

   bis_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .reserved_id (reserved_ff),
      .out_free    (out_free),
      .res_done    (res_done),
      .res         (res)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_done || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = res_done ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff  <= RESERVED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            reserved_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/bis_ram.sv @@
module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/bis_engine.sv @@
module bis_engine #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bis_pkg::req_type req,
   input  logic [31:0]      reserved_id,
   input  logic             out_free,
   output logic             res_done,
   output bis_pkg::rsp_type res
);
   import bis_pkg::*;
   `include "bounded_id_set_assert.svh"

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = AW + CW;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_MOVE   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [1:0]      cmd_ff, cmd_in;
   logic [ID_W-1:0] ident_ff, ident_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   slot_ff, slot_in;
   logic            found_ff, found_in;
   logic            success_ff, success_in;
   logic [CW-1:0]   count_ff, count_in;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [ID_W-1:0] ram_wdata;
   logic [AW-1:0]   ram_raddr;
   logic [ID_W-1:0] ram_rdata;

   logic [EW-1:0]     idx_next;
   logic [CW+5:0]     count_wide;
   logic              req_accept;

   bis_ram #(
      .WIDTH (ID_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign idx_next   = EW'(idx_ff) + EW'(1);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      ident_in   = ident_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      found_in   = found_ff;
      success_in = success_ff;
      count_in   = count_ff;
      ram_we     = 1'b0;
      ram_waddr  = AW'(count_ff);
      ram_wdata  = ident_ff;
      ram_raddr  = AW'(idx_next);
      res_done   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req.cmd;
               ident_in   = req.ident;
               idx_in     = '0;
               slot_in    = '0;
               found_in   = 1'b0;
               success_in = 1'b0;
               ram_raddr  = '0;
               state_in   = (count_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The read data belongs to the entry at idx_ff, whose address was issued in the previous cycle.
            if (ram_rdata == ident_ff) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               state_in = ST_DECIDE;
            end else if (idx_next < EW'(count_ff)) begin
               idx_in = AW'(idx_next);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (cmd_ff == CMD_ADD && !found_ff && ident_ff != reserved_id
                         && count_ff < CW'(CAPACITY)) begin
               ram_we     = 1'b1;
               ram_waddr  = AW'(count_ff);
               ram_wdata  = ident_ff;
               count_in   = count_ff + CW'(1);
               success_in = 1'b1;
               state_in   = ST_FINISH;
            end else if (cmd_ff == CMD_DEL && found_ff && ident_ff != reserved_id) begin
               // Fetch the last entry; it fills the freed slot next cycle.
               ram_raddr = AW'(count_ff - CW'(1));
               state_in  = ST_MOVE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MOVE: begin
            ram_we     = 1'b1;
            ram_waddr  = slot_ff;
            ram_wdata  = ram_rdata;
            count_in   = count_ff - CW'(1);
            success_in = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               res_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cmd_ff     <= cmd_in;
      ident_ff   <= ident_in;
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      success_ff <= success_in;
   end

   assign count_wide   = {6'b0, count_ff};
   assign res.success  = success_ff;
   assign res.found    = found_ff;
   assign res.count    = count_wide[COUNT_W-1:0];
   assign res.is_full  = (count_ff == CW'(CAPACITY));
   assign res.is_empty = (count_ff == '0);

   `BIS_ASSERT(a_count_bound, count_ff <= CW'(CAPACITY), "entry count exceeds capacity")
   `BIS_ASSERT(a_write_state, ram_we |-> (state_ff == ST_DECIDE || state_ff == ST_MOVE),
               "table written outside an update step")
   `BIS_ASSERT(a_move_shrinks, (state_ff == ST_MOVE) |=> (count_ff == $past(count_ff) - CW'(1)),
               "delete did not shrink the count by one")
   `BIS_ASSERT(a_done_free, res_done |-> out_free, "result produced into a busy output")

endmodule

@@ dv/tb_bounded_id_set.sv @@
`timescale 1ns / 100ps

module tb_bounded_id_set;
   import bis_pkg::*;

   localparam int SET_CAPACITY = 32;
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int POOL_SIZE = 40;
   localparam int SETTLE_CYCLES = SET_CAPACITY + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   // Shadow copy of the identifier set, updated as each request is accepted.
   logic [ID_W-1:0] id_table [SET_CAPACITY];
   int unsigned     id_count = 0;
   logic [ID_W-1:0] reserved_now = RESERVED_RESET;
   rsp_type         expected_rsp_q [$];
   logic [ID_W-1:0] id_pool [POOL_SIZE];

   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned rsp_hold_cycles = 0;

   int unsigned error_count = 0;
   int unsigned request_count = 0;
   int unsigned add_ok_count = 0;
   int unsigned del_ok_count = 0;
   int unsigned full_count = 0;
   int unsigned reserved_writes = 0;

   bounded_id_set #(.CAPACITY(SET_CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic rsp_type predict_id_set_op(req_type r);
      int unsigned i;
      int unsigned slot;
      bit          hit;
      rsp_type     e;
      hit = 1'b0;
      slot = 0;
      for (i = 0; i < id_count; i++) begin
         if (!hit && id_table[i] == r.ident) begin
            hit = 1'b1;
            slot = i;
         end
      end
      e.success = 1'b0;
      case (r.cmd)
         CMD_ADD: begin
            if (!hit && r.ident != reserved_now && id_count < SET_CAPACITY) begin
               id_table[id_count] = r.ident;
               id_count++;
               e.success = 1'b1;
               add_ok_count++;
               if (id_count == SET_CAPACITY) full_count++;
            end
         end
         CMD_DEL: begin
            if (id_count != 0 && r.ident != reserved_now && hit) begin
               id_table[slot] = id_table[id_count - 1];
               id_count--;
               e.success = 1'b1;
               del_ok_count++;
            end
         end
         default: ;
      endcase
      e.found = hit;
      e.count = COUNT_W'(id_count);
      e.is_full = (id_count == SET_CAPACITY);
      e.is_empty = (id_count == 0);
      return e;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Response checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response with no request outstanding: %h", rsp);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("success", want.success, rsp.success);
            check_field("found", want.found, rsp.found);
            check_field("count", want.count, rsp.count);
            check_field("is_full", want.is_full, rsp.is_full);
            check_field("is_empty", want.is_empty, rsp.is_empty);
         end
      end
   end

   // Response side: a random stall before each response while rsp_idle_on is set,
   // plus an occasional long hold-off that a test can ask for.
   initial begin : rsp_side
      int unsigned wait_n;
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         wait_n = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (wait_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && rsp_hold_cycles == 0);
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [ID_W-1:0] ident);
      int unsigned gap;
      req_type     item;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      item.cmd = cmd;
      item.ident = ident;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock);
      while (!(req_valid && !req_stall));
      expected_rsp_q.push_back(predict_id_set_op(item));
      request_count++;
   endtask

   // Stop sending, collect every outstanding response and let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reserved(logic [ID_W-1:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      reserved_now = value;
      reserved_writes++;
   endtask

   task automatic refill_pool();
      int i;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();
   endtask

   // Mostly pool values so that adds collide and deletes hit; some stored
   // entries, the reserved value and fully random values mixed in.
   function automatic logic [ID_W-1:0] pick_ident();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return reserved_now;
      if (roll < 16) return $urandom();
      if (roll < 30 && id_count != 0) return id_table[$urandom_range(0, id_count - 1)];
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [1:0] pick_cmd(int unsigned add_pct, int unsigned del_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) return CMD_ADD;
      if (roll < add_pct + del_pct) return CMD_DEL;
      if (roll < 95) return CMD_QUERY;
      return CMD_SPARE;
   endfunction

   task automatic test_edge_cases();
      send_request(CMD_QUERY, '0);
      send_request(CMD_DEL, 32'd5);
      send_request(CMD_ADD, '1);
      send_request(CMD_ADD, '0);
      send_request(CMD_ADD, 32'hFFFF_FFFE);
      send_request(CMD_ADD, '0);
      send_request(CMD_ADD, 32'hAAAA_AAAA);
      send_request(CMD_ADD, 32'h5555_5555);
      send_request(CMD_QUERY, '1);
      send_request(CMD_SPARE, 32'hFFFF_FFFE);
      send_request(CMD_SPARE, 32'h1234_5678);
      send_request(CMD_DEL, 32'h1234_5678);
      send_request(CMD_DEL, '1);
      // Deleting the first entry moves the last one into its slot.
      send_request(CMD_DEL, '0);
      send_request(CMD_QUERY, 32'h5555_5555);
      send_request(CMD_DEL, 32'h5555_5555);
      send_request(CMD_DEL, 32'hFFFF_FFFE);
      send_request(CMD_DEL, 32'hAAAA_AAAA);
   endtask

   task automatic test_reserved_register();
      write_reserved('0);
      send_request(CMD_ADD, '0);
      send_request(CMD_ADD, '1);
      send_request(CMD_ADD, 32'd7);
      // The all-ones entry stays stored after it becomes the reserved value.
      write_reserved('1);
      send_request(CMD_QUERY, '1);
      send_request(CMD_DEL, '1);
      send_request(CMD_ADD, '1);
      write_reserved(32'd7);
      send_request(CMD_DEL, 32'd7);
      send_request(CMD_QUERY, 32'd7);
      write_reserved(32'h8000_0000);
      send_request(CMD_DEL, '1);
      send_request(CMD_DEL, 32'd7);
   endtask

   task automatic test_full_table();
      int unsigned n;
      write_reserved(RESERVED_RESET);
      while (id_count < SET_CAPACITY) send_request(CMD_ADD, $urandom());
      send_request(CMD_ADD, $urandom());
      send_request(CMD_ADD, id_table[$urandom_range(0, SET_CAPACITY - 1)]);
      send_request(CMD_QUERY, id_table[SET_CAPACITY - 1]);
      send_request(CMD_SPARE, id_table[0]);
      n = 0;
      while (id_count != 0) begin
         if (n % 5 == 4) send_request(CMD_DEL, $urandom());
         else send_request(CMD_DEL, id_table[$urandom_range(0, id_count - 1)]);
         n++;
      end
   endtask

   task automatic test_backpressure();
      int i;
      refill_pool();
      req_idle_on = 1'b0;
      rsp_hold_cycles = 150;
      for (i = 0; i < 30; i++) send_request(pick_cmd(50, 25), pick_ident());
      wait_idle();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_mix();
      int unsigned phase;
      int unsigned i;
      int unsigned add_pct;
      int unsigned del_pct;
      for (phase = 0; phase < 12; phase++) begin
         refill_pool();
         case (phase % 4)
            0: write_reserved($urandom());
            1: write_reserved('0);
            2: write_reserved('1);
            default: begin
               if (id_count != 0) write_reserved(id_table[$urandom_range(0, id_count - 1)]);
               else write_reserved(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
         endcase
         case (phase % 3)
            0: begin add_pct = 65; del_pct = 15; end
            1: begin add_pct = 40; del_pct = 35; end
            default: begin add_pct = 20; del_pct = 60; end
         endcase
         req_idle_on = (phase % 5 != 4);
         rsp_idle_on = (phase % 7 != 3);
         for (i = 0; i < 150; i++) send_request(pick_cmd(add_pct, del_pct), pick_ident());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_reserved_register();
      test_full_table();
      test_backpressure();
      test_random_mix();
      wait_idle();
      $display("Sent %0d requests under %0d reserved-id settings.",
               request_count, reserved_writes + 1);
      $display("%0d adds and %0d deletes succeeded; the table filled up %0d times.",
               add_ok_count, del_ok_count, full_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
